// ----- sv/mlfqs_pkg.sv -----
`timescale 1ns / 1ps
package mlfqs_pkg;
  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_LOAD   = 3'd1,
    CMD_DECAY  = 3'd2,
    CMD_NICE   = 3'd3,
    CMD_QUERY  = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_MUL,
    ST_MUL2,
    ST_WRITE,
    ST_PRI,
    ST_PRI2
  } state_e;

  localparam int unsigned PriTop = 63;
  localparam int signed NiceLo = -20;
  localparam int signed NiceHi = 20;
endpackage

// ----- sv/mlfqs_ram.sv -----
`timescale 1ns / 1ps
module mlfqs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- sv/mlfqs_div.sv -----
`timescale 1ns / 1ps
module mlfqs_div #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 34
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  localparam int unsigned RemW = DenW + 1;

  logic [NumW-1:0] quo_q, quo_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            run_q, run_d, done_q, done_d;
  logic [RemW-1:0] sh;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    sh     = {rem_q[RemW-2:0], quo_q[NumW-1]};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = CntW'(NumW);
      run_d = 1'b1;
    end else if (run_q) begin
      if (sh >= {1'b0, den_q}) begin
        rem_d = sh - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = sh;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule

// ----- sv/mlfqs_priority_engine_unit.sv -----
`timescale 1ns / 1ps
// Each command steps through READ, EXEC, WRITE, PRI and PRI2 before the
// registered result strobe; decay adds DIV (skipped when 2*load+1 is not
// positive), MUL and MUL2, with DIV waiting on the bit-serial divider (47
// quotient bits, one per cycle). One command at a time; busy stays high until
// the result strobe, so no new beat is taken before the last one is through.
// After reset a clearing pass zeroes the thread tables; busy is high during it. The receiver cannot stall the result.
module mlfqs_priority_engine_unit
  import mlfqs_pkg::*;
#(
  parameter int unsigned THREADS   = 64,
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        command_i,
  input  logic [5:0]        thread_index_i,
  input  logic              cpu_idle_i,
  input  logic [6:0]        ready_count_i,
  input  logic signed [5:0] nice_value_i,
  output logic              strobe_o,
  output logic [5:0]        priority_res_o,
  output logic [30:0]       load_average_o,
  output logic signed [31:0] recent_cpu_out_o
);
  localparam int unsigned AW   = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int unsigned NumW = 33 + FRAC_BITS;
  localparam int unsigned DenW = 34;
  localparam longint K59 = (64'sd59 <<< FRAC_BITS) / 60;
  localparam longint K1  = (64'sd1 <<< FRAC_BITS) / 60;
  localparam longint OneFp = 64'sd1 <<< FRAC_BITS;

  state_e st_q, st_d;
  logic [AW-1:0] idx_q, idx_d, clr_q, clr_d;
  logic [2:0] cmd_q;
  logic idle_q;
  logic [6:0] ready_q;
  logic signed [5:0] nicein_q;
  logic signed [31:0] load_q, load_d;
  logic signed [31:0] rc_q, rc_d;
  logic signed [5:0] ni_q, ni_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [33:0] pri_q, pri_d;
  logic [5:0] pres_q, pres_d;
  logic strobe_q, strobe_d;

  logic rc_we, ni_we;
  logic [AW-1:0] waddr;
  logic [31:0] rc_wdata, rc_rdata;
  logic [5:0] ni_wdata, ni_rdata;
  logic div_start, div_done;
  logic [NumW-1:0] div_num, div_q;
  logic [DenW-1:0] div_den;
  logic signed [33:0] two_load;
  logic signed [31:0] rc_rd_s;
  logic signed [5:0] ni_rd_s;
  logic [AW-1:0] idx_in;
  logic signed [47:0] mul_res;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // index modulo THREADS by shift and compare-subtract
  function automatic logic [AW-1:0] wrap_idx(input logic [5:0] v);
    logic [10:0] r;
    r = '0;
    for (int i = 5; i >= 0; i--) begin
      r = {r[9:0], v[i]};
      if (r >= 11'(THREADS)) r = r - 11'(THREADS);
    end
    return AW'(r);
  endfunction

  assign idx_in  = wrap_idx(thread_index_i);
  assign rc_rd_s = rc_rdata;
  assign ni_rd_s = ni_rdata;
  assign two_load = {load_q[31], load_q, 1'b0};

  mlfqs_ram #(.Width(32), .Depth(THREADS)) u_rc (
    .clk_i, .we_i(rc_we), .waddr_i(waddr), .wdata_i(rc_wdata),
    .raddr_i(idx_q), .rdata_o(rc_rdata));
  mlfqs_ram #(.Width(6), .Depth(THREADS)) u_ni (
    .clk_i, .we_i(ni_we), .waddr_i(waddr), .wdata_i(ni_wdata),
    .raddr_i(idx_q), .rdata_o(ni_rdata));

  assign div_num = NumW'($unsigned(two_load)) << FRAC_BITS;
  assign div_den = DenW'($unsigned(two_load + 34'(OneFp)));

  mlfqs_div #(.NumW(NumW), .DenW(DenW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_q));

  // decay factor is below 1.0, so it fits in 16 bits
  assign mul_res = $signed({1'b0, prod_q[15:0]}) * rc_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_CLEAR: if (clr_q == AW'(THREADS - 1)) st_d = ST_IDLE;
      ST_IDLE:  if (start) st_d = ST_READ;
      ST_READ:  st_d = ST_EXEC;
      ST_EXEC: begin
        if (cmd_q == CMD_DECAY) begin
          st_d = (load_q < 0 && two_load + 34'(OneFp) <= 0) ? ST_MUL : ST_DIV;
        end else begin
          st_d = ST_WRITE;
        end
      end
      ST_DIV:   if (div_done) st_d = ST_MUL;
      ST_MUL:   st_d = ST_MUL2;
      ST_MUL2:  st_d = ST_WRITE;
      ST_WRITE: st_d = ST_PRI;
      ST_PRI:   st_d = ST_PRI2;
      ST_PRI2:  st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (st_q != ST_IDLE);
    div_start = (st_q == ST_EXEC) && (cmd_q == CMD_DECAY);
    rc_we     = (st_q == ST_CLEAR) || ((st_q == ST_WRITE) &&
                ((cmd_q == CMD_TICK) || (cmd_q == CMD_DECAY)));
    ni_we     = (st_q == ST_CLEAR) || ((st_q == ST_WRITE) && (cmd_q == CMD_NICE));
    waddr     = (st_q == ST_CLEAR) ? clr_q : idx_q;
    rc_wdata  = (st_q == ST_CLEAR) ? '0 : rc_q;
    ni_wdata  = (st_q == ST_CLEAR) ? '0 : ni_q;
  end

  always_comb begin
    clr_d    = (st_q == ST_CLEAR) ? clr_q + 1'b1 : clr_q;
    idx_d    = idx_q;
    load_d   = load_q;
    rc_d     = rc_q;
    ni_d     = ni_q;
    prod_d   = prod_q;
    pri_d    = pri_q;
    pres_d   = pres_q;
    strobe_d = 1'b0;
    case (st_q)
      ST_IDLE: if (start) idx_d = idx_in;
      ST_EXEC: begin
        rc_d = rc_rd_s;
        ni_d = ni_rd_s;
        case (cmd_q)
          CMD_TICK: begin
            if (!idle_q) rc_d = sat32(64'(rc_rd_s) + OneFp);
          end
          CMD_LOAD: begin
            load_d = sat32(((K59 * 64'(load_q)) >>> FRAC_BITS) +
                     K1 * 64'({1'b0, ready_q} + (idle_q ? 8'd0 : 8'd1)));
          end
          CMD_NICE: begin
            if (nicein_q < 6'(NiceLo)) ni_d = 6'(NiceLo);
            else if (nicein_q > 6'(NiceHi)) ni_d = 6'(NiceHi);
            else ni_d = nicein_q;
          end
          default: ;
        endcase
        prod_d = '0;
      end
      ST_DIV: if (div_done) prod_d = 64'($signed({1'b0, div_q[32:0]}));
      ST_MUL: prod_d = 64'(mul_res);
      ST_MUL2: rc_d = sat32((prod_q >>> FRAC_BITS) + (64'(ni_q) <<< FRAC_BITS));
      ST_WRITE: begin
        pri_d = (34'(PriTop) <<< FRAC_BITS) -
                34'((rc_q < 0) ? -((-64'(rc_q)) >>> 2) : (64'(rc_q) >>> 2));
      end
      ST_PRI: begin
        pri_d = (pri_q - (34'(ni_q) <<< (FRAC_BITS + 1))) >>> FRAC_BITS;
      end
      ST_PRI2: begin
        if (pri_q < 0) pres_d = '0;
        else if (pri_q > 34'(PriTop)) pres_d = 6'(PriTop);
        else pres_d = pri_q[5:0];
        strobe_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_CLEAR;
      clr_q    <= '0;
      load_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      clr_q    <= clr_d;
      load_q   <= load_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    rc_q   <= rc_d;
    ni_q   <= ni_d;
    prod_q <= prod_d;
    pri_q  <= pri_d;
    pres_q <= pres_d;
    if (st_q == ST_IDLE && start) begin
      cmd_q    <= command_i;
      idle_q   <= cpu_idle_i;
      ready_q  <= ready_count_i;
      nicein_q <= nice_value_i;
    end
  end

  assign strobe_o         = strobe_q;
  assign priority_res_o   = pres_q;
  assign load_average_o   = load_q[30:0];
  assign recent_cpu_out_o = rc_q;
endmodule
